/* rtl/apspc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// apspc_pkg
// Shared types and constants of the graph center core.
// ----------------------------------------------------------------------------
package apspc_pkg;

  localparam int unsigned MaxVerticesDef = 128;
  localparam int unsigned VertexW        = 7;
  localparam int unsigned WeightW        = 16;
  localparam int unsigned CountW         = 8;
  localparam logic [WeightW-1:0] Unreach = 16'hFFFF;

  typedef enum logic [1:0] {
    WR_LOOP,
    WR_AB,
    WR_BA,
    WR_CLEAR
  } wr_src_e;

  typedef struct packed {
    logic    cap_in;
    logic    wr_en;
    wr_src_e wr_src;
    logic    cap_dik;
    logic    worst_clr;
    logic    worst_upd;
    logic    best_init;
    logic    best_eval;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic in_edge_ok;
    logic in_last;
    logic last_q;
    logic worst_unreach;
    logic out_busy;
  } stat_t;

endpackage
`default_nettype wire

/* rtl/all_pairs_shortest_path_center_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// all_pairs_shortest_path_center_core
// Graph center finder over an all-pairs shortest path distance matrix.
// ----------------------------------------------------------------------------
// An edge beat is accepted and then written once per direction (states EDGE1
// and EDGE2); a beat that neither carries an edge nor ends the job is only
// accepted. After the last beat the relaxation visits every k, i and j
// below n, n being the clamped vertex count, reading and then updating each
// cell, and the center search scans every row, stopping early at a row with an
// unreachable vertex. A clearing pass after reset and after each result writes
// all 2**(2*clog2(MAX_VERTICES)) RAM entries (16384 by default); no beat is
// accepted then, and the result stays in its output register until taken.
module all_pairs_shortest_path_center_core #(
  parameter int unsigned MAX_VERTICES = apspc_pkg::MaxVerticesDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          vertex_count_we_i,
  input  wire logic [apspc_pkg::CountW-1:0]  vertex_count_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          edge_present_i,
  input  wire logic [apspc_pkg::VertexW-1:0] first_vertex_i,
  input  wire logic [apspc_pkg::VertexW-1:0] second_vertex_i,
  input  wire logic [apspc_pkg::WeightW-1:0] weight_i,
  input  wire logic                          last_edge_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               found_o,
  output logic      [apspc_pkg::VertexW-1:0] best_vertex_o,
  output logic      [apspc_pkg::WeightW-1:0] best_distance_o
);
  import apspc_pkg::*;

  localparam int unsigned VW = $clog2(MAX_VERTICES);
  localparam int unsigned AW = 2 * VW;

  cmd_t          cmd;
  stat_t         stat;
  logic [VW-1:0] last_idx, row;
  logic [AW-1:0] wr_addr, rd0_addr, rd1_addr;

  apspc_ctrl #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .last_idx_i (last_idx),
    .cmd_o      (cmd),
    .row_o      (row),
    .wr_addr_o  (wr_addr),
    .rd0_addr_o (rd0_addr),
    .rd1_addr_o (rd1_addr)
  );

  apspc_dpath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .vertex_count_we_i (vertex_count_we_i),
    .vertex_count_i    (vertex_count_i),
    .edge_present_i    (edge_present_i),
    .first_vertex_i    (first_vertex_i),
    .second_vertex_i   (second_vertex_i),
    .weight_i          (weight_i),
    .last_edge_i       (last_edge_i),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .last_idx_o        (last_idx),
    .row_i             (row),
    .wr_addr_i         (wr_addr),
    .rd0_addr_i        (rd0_addr),
    .rd1_addr_i        (rd1_addr),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .found_o           (found_o),
    .best_vertex_o     (best_vertex_o),
    .best_distance_o   (best_distance_o)
  );

endmodule
`default_nettype wire

/* rtl/apspc_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// apspc_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module apspc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16384
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr0_i,
  output logic      [WIDTH-1:0]         rdata0_o,
  input  wire logic [$clog2(DEPTH)-1:0] raddr1_i,
  output logic      [WIDTH-1:0]         rdata1_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata0_o <= mem_q[raddr0_i];
    rdata1_o <= mem_q[raddr1_i];
  end

endmodule
`default_nettype wire

/* rtl/apspc_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// apspc_ctrl
// Sequencer for loading, clearing, relaxation and the center search.
// ----------------------------------------------------------------------------
module apspc_ctrl #(
  parameter int unsigned MAX_VERTICES = apspc_pkg::MaxVerticesDef,
  localparam int unsigned VW = $clog2(MAX_VERTICES),
  localparam int unsigned AW = 2 * VW
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire apspc_pkg::stat_t  stat_i,
  input  wire logic [VW-1:0]     last_idx_i,
  output apspc_pkg::cmd_t        cmd_o,
  output logic      [VW-1:0]     row_o,
  output logic      [AW-1:0]     wr_addr_o,
  output logic      [AW-1:0]     rd0_addr_o,
  output logic      [AW-1:0]     rd1_addr_o
);
  import apspc_pkg::*;

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_EDGE1  = 4'd2;
  localparam logic [3:0] S_EDGE2  = 4'd3;
  localparam logic [3:0] S_FWINIT = 4'd4;
  localparam logic [3:0] S_RIK    = 4'd5;
  localparam logic [3:0] S_LIK    = 4'd6;
  localparam logic [3:0] S_RJ     = 4'd7;
  localparam logic [3:0] S_WJ     = 4'd8;
  localparam logic [3:0] S_CINIT  = 4'd9;
  localparam logic [3:0] S_CROW   = 4'd10;
  localparam logic [3:0] S_CRJ    = 4'd11;
  localparam logic [3:0] S_CWJ    = 4'd12;
  localparam logic [3:0] S_CEVAL  = 4'd13;
  localparam logic [3:0] S_OUT    = 4'd14;

  logic [3:0]    state_q, state_d;
  logic [VW-1:0] k_q, k_d, i_q, i_d, j_q, j_d;
  logic [AW-1:0] clr_q, clr_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      k_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      i_q     <= i_d;
      j_q     <= j_d;
      clr_q   <= clr_d;
    end
  end

  assign row_o = i_q;

  always_comb begin
    state_d    = state_q;
    k_d        = k_q;
    i_d        = i_q;
    j_d        = j_q;
    clr_d      = clr_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    wr_addr_o  = {i_q, j_q};
    rd0_addr_o = {i_q, j_q};
    rd1_addr_o = {i_q, j_q};
    case (state_q)
      S_CLEAR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_src = WR_CLEAR;
        wr_addr_o    = clr_q;
        clr_d        = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap_in = 1'b1;
          if (stat_i.in_edge_ok) begin
            state_d = S_EDGE1;
          end else if (stat_i.in_last) begin
            state_d = S_FWINIT;
          end
        end
      end
      S_EDGE1: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_src = WR_AB;
        state_d      = S_EDGE2;
      end
      S_EDGE2: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_src = WR_BA;
        state_d      = stat_i.last_q ? S_FWINIT : S_IDLE;
      end
      S_FWINIT: begin
        k_d     = '0;
        i_d     = '0;
        state_d = S_RIK;
      end
      S_RIK: begin
        rd0_addr_o = {i_q, k_q};
        state_d    = S_LIK;
      end
      S_LIK: begin
        cmd_o.cap_dik = 1'b1;
        j_d           = '0;
        state_d       = S_RJ;
      end
      S_RJ: begin
        rd0_addr_o = {k_q, j_q};
        rd1_addr_o = {i_q, j_q};
        state_d    = S_WJ;
      end
      S_WJ: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_src = WR_LOOP;
        if (j_q == last_idx_i) begin
          state_d = S_RIK;
          if (i_q == last_idx_i) begin
            i_d = '0;
            if (k_q == last_idx_i) begin
              state_d = S_CINIT;
            end else begin
              k_d = k_q + 1'b1;
            end
          end else begin
            i_d = i_q + 1'b1;
          end
        end else begin
          j_d     = j_q + 1'b1;
          state_d = S_RJ;
        end
      end
      S_CINIT: begin
        cmd_o.best_init = 1'b1;
        i_d             = '0;
        state_d         = S_CROW;
      end
      S_CROW: begin
        cmd_o.worst_clr = 1'b1;
        j_d             = '0;
        state_d         = S_CRJ;
      end
      S_CRJ: begin
        state_d = S_CWJ;
      end
      S_CWJ: begin
        cmd_o.worst_upd = (j_q != i_q);
        if (j_q == last_idx_i) begin
          state_d = S_CEVAL;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = S_CRJ;
        end
      end
      S_CEVAL: begin
        cmd_o.best_eval = 1'b1;
        if (stat_i.worst_unreach || (i_q == last_idx_i)) begin
          state_d = S_OUT;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = S_CROW;
        end
      end
      S_OUT: begin
        if (!stat_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          clr_d          = '0;
          state_d        = S_CLEAR;
        end
      end
      default: begin
        state_d = S_CLEAR;
        clr_d   = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

/* rtl/apspc_dpath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// apspc_dpath
// Distance matrix, relaxation adder, eccentricity tracking and result register.
// ----------------------------------------------------------------------------
module apspc_dpath #(
  parameter int unsigned MAX_VERTICES = apspc_pkg::MaxVerticesDef,
  localparam int unsigned VW = $clog2(MAX_VERTICES),
  localparam int unsigned AW = 2 * VW
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            vertex_count_we_i,
  input  wire logic [apspc_pkg::CountW-1:0]    vertex_count_i,
  input  wire logic                            edge_present_i,
  input  wire logic [apspc_pkg::VertexW-1:0]   first_vertex_i,
  input  wire logic [apspc_pkg::VertexW-1:0]   second_vertex_i,
  input  wire logic [apspc_pkg::WeightW-1:0]   weight_i,
  input  wire logic                            last_edge_i,
  input  wire apspc_pkg::cmd_t                 cmd_i,
  output apspc_pkg::stat_t                     stat_o,
  output logic      [VW-1:0]                   last_idx_o,
  input  wire logic [VW-1:0]                   row_i,
  input  wire logic [AW-1:0]                   wr_addr_i,
  input  wire logic [AW-1:0]                   rd0_addr_i,
  input  wire logic [AW-1:0]                   rd1_addr_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic                                 found_o,
  output logic      [apspc_pkg::VertexW-1:0]   best_vertex_o,
  output logic      [apspc_pkg::WeightW-1:0]   best_distance_o
);
  import apspc_pkg::*;

  function automatic logic [VW-1:0] vidx(input logic [VertexW-1:0] v);
    logic [31:0] t;
    t = 32'(v);
    return t[VW-1:0];
  endfunction

  logic [CountW-1:0]  vc_q;
  logic [VW-1:0]      a_q, b_q;
  logic [WeightW-1:0] w_q, dik_q, worst_q, best_q;
  logic [VertexW-1:0] bidx_q;
  logic               last_q, fail_q, out_valid_q;
  logic [WeightW-1:0] rdata0, rdata1;
  logic [WeightW:0]   sum;
  logic               take;
  logic [31:0]        n_w, nm1_w, row_w;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [WeightW-1:0] ram_wdata;

  always_comb begin
    if (vc_q == '0) begin
      n_w = 32'd1;
    end else if (32'(vc_q) > 32'(MAX_VERTICES)) begin
      n_w = 32'(MAX_VERTICES);
    end else begin
      n_w = 32'(vc_q);
    end
    nm1_w = n_w - 32'd1;
  end
  assign last_idx_o = nm1_w[VW-1:0];
  assign row_w      = 32'(row_i);

  assign sum  = {1'b0, dik_q} + {1'b0, rdata0};
  assign take = ({1'b0, rdata1} > sum);

  always_comb begin
    ram_waddr = wr_addr_i;
    ram_wdata = sum[WeightW-1:0];
    case (cmd_i.wr_src)
      WR_AB: begin
        ram_waddr = {a_q, b_q};
        ram_wdata = w_q;
      end
      WR_BA: begin
        ram_waddr = {b_q, a_q};
        ram_wdata = w_q;
      end
      WR_CLEAR: begin
        ram_wdata = Unreach;
      end
      default: begin
        ram_wdata = sum[WeightW-1:0];
      end
    endcase
  end
  assign ram_we = cmd_i.wr_en && ((cmd_i.wr_src != WR_LOOP) || take);

  apspc_ram #(
    .WIDTH (WeightW),
    .DEPTH (1 << AW)
  ) u_ram (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (ram_waddr),
    .wdata_i  (ram_wdata),
    .raddr0_i (rd0_addr_i),
    .rdata0_o (rdata0),
    .raddr1_i (rd1_addr_i),
    .rdata1_o (rdata1)
  );

  assign stat_o.in_edge_ok    = edge_present_i &&
                                (32'(first_vertex_i) < 32'(MAX_VERTICES)) &&
                                (32'(second_vertex_i) < 32'(MAX_VERTICES));
  assign stat_o.in_last       = last_edge_i;
  assign stat_o.last_q        = last_q;
  assign stat_o.worst_unreach = (worst_q == Unreach);
  assign stat_o.out_busy      = out_valid_q && !out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q        <= CountW'(1);
      last_q      <= 1'b0;
      fail_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (vertex_count_we_i) begin
        vc_q <= vertex_count_i;
      end
      if (cmd_i.cap_in) begin
        last_q <= last_edge_i;
      end
      if (cmd_i.best_init) begin
        fail_q <= 1'b0;
      end else if (cmd_i.best_eval && (worst_q == Unreach)) begin
        fail_q <= 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      a_q <= vidx(first_vertex_i);
      b_q <= vidx(second_vertex_i);
      w_q <= weight_i;
    end
    if (cmd_i.cap_dik) begin
      dik_q <= rdata0;
    end
    if (cmd_i.worst_clr) begin
      worst_q <= '0;
    end else if (cmd_i.worst_upd && (rdata0 > worst_q)) begin
      worst_q <= rdata0;
    end
    if (cmd_i.best_init) begin
      best_q <= Unreach;
      bidx_q <= '0;
    end else if (cmd_i.best_eval && (worst_q != Unreach) && (worst_q < best_q)) begin
      best_q <= worst_q;
      bidx_q <= row_w[VertexW-1:0];
    end
    if (cmd_i.out_load) begin
      found_o         <= !fail_q;
      best_vertex_o   <= fail_q ? '0 : bidx_q;
      best_distance_o <= fail_q ? '0 : best_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

/* rtl/apspc_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// apspc_checker
// Port-level checks of the graph center core, bound to the top level.
// ----------------------------------------------------------------------------
module apspc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        last_edge_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic        found_o,
  input wire logic [6:0]  best_vertex_o,
  input wire logic [15:0] best_distance_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(found_o) &&
      $stable(best_vertex_o) && $stable(best_distance_o))
    else $error("result beat changed while stalled");

  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> (best_vertex_o == 7'd0) && (best_distance_o == 16'd0))
    else $error("not-found result carries nonzero fields");

  a_found_reach: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> best_distance_o != 16'hFFFF)
    else $error("found result with unreachable distance");

  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && last_edge_i |=> !in_ready_o)
    else $error("input ready right after the last beat");

endmodule

bind all_pairs_shortest_path_center_core apspc_checker u_apspc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .last_edge_i     (last_edge_i),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .found_o         (found_o),
  .best_vertex_o   (best_vertex_o),
  .best_distance_o (best_distance_o)
);
`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the graph center core. Edge beats are driven from
// a queue with random idle bursts on both channels; a local shortest path
// predictor computes each expected center, and results are compared in order.
// ----------------------------------------------------------------------------
module tb;

  import apspc_pkg::*;

  typedef struct {
    bit               present;
    bit [VertexW-1:0] va;
    bit [VertexW-1:0] vb;
    bit [WeightW-1:0] w;
    bit               last;
  } edge_beat_t;

  typedef struct {
    bit               found;
    bit [VertexW-1:0] vertex;
    bit [WeightW-1:0] best_dist;
  } center_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CountW-1:0]   cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                edge_present = 1'b0;
  logic [VertexW-1:0]  first_vertex = '0;
  logic [VertexW-1:0]  second_vertex = '0;
  logic [WeightW-1:0]  weight = '0;
  logic                last_edge = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                found;
  logic [VertexW-1:0]  best_vertex;
  logic [WeightW-1:0]  best_distance;

  edge_beat_t       pending_beats[$];
  center_t          expected_centers[$];
  bit [WeightW-1:0] dist_mat[0:127][0:127];
  bit [CountW-1:0]  vertex_count_copy = 1;
  int               errors = 0;
  int               items_made = 0;
  int               in_gap = 0;
  int               out_gap = 0;
  int               hold_left = 0;
  bit               hold_start = 0;
  bit               quiet = 0;

  all_pairs_shortest_path_center_core dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .vertex_count_we_i (cfg_we),
    .vertex_count_i    (cfg_data),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .edge_present_i    (edge_present),
    .first_vertex_i    (first_vertex),
    .second_vertex_i   (second_vertex),
    .weight_i          (weight),
    .last_edge_i       (last_edge),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .found_o           (found),
    .best_vertex_o     (best_vertex),
    .best_distance_o   (best_distance)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic void clear_matrix();
    for (int i = 0; i < 128; i++)
      for (int j = 0; j < 128; j++) dist_mat[i][j] = Unreach;
  endfunction

  function automatic void predict_center(edge_beat_t b);
    int      n;
    int      s;
    int      worst;
    center_t c;
    if (b.present) begin
      dist_mat[b.va][b.vb] = b.w;
      dist_mat[b.vb][b.va] = b.w;
    end
    if (!b.last) return;
    n = vertex_count_copy;
    if (n == 0) n = 1;
    if (n > 128) n = 128;
    for (int k = 0; k < n; k++)
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++) begin
          s = dist_mat[i][k] + dist_mat[k][j];
          if (dist_mat[i][j] > s) dist_mat[i][j] = s[15:0];
        end
    c.found = 1'b1;
    c.vertex = '0;
    c.best_dist = Unreach;
    for (int i = 0; i < n && c.found; i++) begin
      worst = 0;
      for (int j = 0; j < n; j++)
        if (j != i && dist_mat[i][j] > worst) worst = dist_mat[i][j];
      if (worst == Unreach) c.found = 1'b0;
      else if (worst < c.best_dist) begin
        c.best_dist = worst[WeightW-1:0];
        c.vertex = i[VertexW-1:0];
      end
    end
    if (!c.found) begin
      c.vertex = '0;
      c.best_dist = '0;
    end
    expected_centers.push_back(c);
    clear_matrix();
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        predict_center(pending_beats.pop_front());
      end
      if (in_valid && !in_ready) begin
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_beats.size() > 0 && !quiet && $urandom_range(0, 11) == 0) begin
        in_gap <= $urandom_range(0, 18);
        in_valid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        in_valid <= 1'b1;
        edge_present <= pending_beats[0].present;
        first_vertex <= pending_beats[0].va;
        second_vertex <= pending_beats[0].vb;
        weight <= pending_beats[0].w;
        last_edge <= pending_beats[0].last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_start) hold_left <= 30000;
    else if (hold_left > 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk_i) begin
    center_t c;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (expected_centers.size() == 0) begin
          if (errors < 10) $display("unexpected result beat");
          errors++;
        end else begin
          c = expected_centers.pop_front();
          if (found !== c.found || best_vertex !== c.vertex ||
              best_distance !== c.best_dist) begin
            if (errors < 10)
              $display("mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                       c.found, c.vertex, c.best_dist, found, best_vertex, best_distance);
            errors++;
          end
        end
      end
      if (hold_start || hold_left > 1) begin
        out_ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_gap <= $urandom_range(0, 18);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic add_beat(bit p, int a, int b, int w, bit l);
    edge_beat_t e;
    e.present = p;
    e.va = a[VertexW-1:0];
    e.vb = b[VertexW-1:0];
    e.w = w[WeightW-1:0];
    e.last = l;
    pending_beats.push_back(e);
    items_made++;
  endtask

  task automatic set_count(int v);
    while (pending_beats.size() > 0 || in_valid || expected_centers.size() > 0)
      @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_data <= v[CountW-1:0];
    @(posedge clk_i);
    cfg_we <= 1'b0;
    vertex_count_copy = v[CountW-1:0];
  endtask

  function automatic int rand_weight();
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom_range(0, 15);
      3:       return $urandom_range(0, 1) ? 65534 : 65535;
      4:       return $urandom_range(30000, 65534);
      default: return $urandom_range(0, 65534);
    endcase
  endfunction

  task automatic random_job(int n);
    int perm[128];
    int t;
    int x;
    int skip;
    bit l;
    for (int i = 0; i < n; i++) perm[i] = i;
    for (int i = n - 1; i > 0; i--) begin
      x = $urandom_range(0, i);
      t = perm[i];
      perm[i] = perm[x];
      perm[x] = t;
    end
    skip = ($urandom_range(0, 9) == 0) ? $urandom_range(1, n) : 0;
    for (int i = 1; i < n; i++)
      if (i != skip) add_beat(1, perm[i - 1], perm[i], rand_weight(), 0);
    for (int i = $urandom_range(0, 6); i > 0; i--) begin
      case ($urandom_range(0, 7))
        0:       add_beat(1, $urandom_range(0, 127), $urandom_range(0, 127),
                          $urandom_range(0, 65535), 0);
        1:       add_beat(0, $urandom_range(0, 127), $urandom_range(0, 127),
                          $urandom_range(0, 65535), 0);
        default: add_beat(1, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
                          rand_weight(), 0);
      endcase
    end
    l = $urandom_range(0, 3) == 0;
    if (l) add_beat(0, $urandom_range(0, 127), $urandom_range(0, 127),
                    $urandom_range(0, 65535), 1);
    else add_beat(1, $urandom_range(0, n - 1), $urandom_range(0, n - 1), rand_weight(), 1);
  endtask

  initial begin
    clear_matrix();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_count(1);
    add_beat(0, 0, 0, 0, 1);
    set_count(0);
    add_beat(1, 1, 2, 5, 1);
    set_count(2);
    add_beat(1, 0, 1, 65535, 1);
    set_count(2);
    add_beat(1, 0, 1, 9, 0);
    add_beat(1, 1, 0, 65534, 0);
    add_beat(1, 0, 0, 3, 0);
    add_beat(1, 127, 127, 65535, 0);
    add_beat(0, 85, 42, 21845, 0);
    add_beat(0, 0, 0, 0, 1);
    set_count(3);
    add_beat(1, 0, 1, 40000, 0);
    add_beat(1, 1, 2, 40000, 1);
    set_count(3);
    add_beat(1, 0, 1, 0, 0);
    add_beat(1, 1, 2, 0, 0);
    add_beat(1, 0, 2, 7, 0);
    add_beat(1, 127, 1, 1, 1);
    set_count(4);
    add_beat(1, 0, 1, 2, 0);
    add_beat(1, 1, 2, 2, 0);
    add_beat(1, 2, 3, 2, 1);

    set_count(5);
    @(posedge clk_i);
    hold_start <= 1'b1;
    @(posedge clk_i);
    hold_start <= 1'b0;
    random_job(5);
    random_job(5);
    random_job(5);

    set_count(24);
    random_job(24);

    while (items_made < 450) begin
      if (items_made > 400) quiet = 1;
      if ($urandom_range(0, 4) != 0) begin
        case ($urandom_range(0, 9))
          0:       set_count($urandom_range(9, 12));
          1:       set_count($urandom_range(0, 1));
          default: set_count($urandom_range(2, 8));
        endcase
      end
      random_job((vertex_count_copy < 2) ? 1 : vertex_count_copy);
    end

    while (pending_beats.size() > 0 || in_valid || expected_centers.size() > 0)
      @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

  initial begin
    #500000000;
    $display("tb failed");
    $finish;
  end

endmodule

/* filelist.f */
rtl/apspc_pkg.sv
rtl/apspc_ram.sv
rtl/apspc_ctrl.sv
rtl/apspc_dpath.sv
rtl/all_pairs_shortest_path_center_core.sv
rtl/apspc_checker.sv
dv/tb.sv
